// ===== sv/multi_queue_linked_list_manager_unit_assert.svh =====
// Assertion macros shared by the checker of the linked list queue manager.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef MULTI_QUEUE_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH
`define MULTI_QUEUE_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MQLL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MQLL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mqll_pkg.sv =====
// Types, codes and constants of the linked list queue manager.
// Depends on nothing; imported by every module of the block.
package mqll_pkg;

    localparam int SLOTS       = 64;
    localparam int QUEUES      = 16;
    localparam int SLOT_W      = 6;
    localparam int QUEUE_W     = 4;
    localparam int PTR_W       = SLOT_W + 1;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [QUEUE_W-1:0] t_qid;
    typedef logic [PTR_W-1:0]   t_ptr;

    // A null pointer has its top bit set.
    localparam t_ptr NIL_PTR = t_ptr'(SLOTS);

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_QUEUED     = 2'd2,
        ST_NOT_QUEUED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    // Write request to the head, tail and queued-flag table.
    typedef struct packed {
        logic  head_we;
        logic  tail_we;
        t_qid  qid;
        t_ptr  head_data;
        t_ptr  tail_data;
        logic  flag_we;
        t_slot flag_slot;
        logic  flag_val;
    } t_qt_wr;

    // Request to the per-slot link memories.
    typedef struct packed {
        logic  rd_en;
        t_slot next_rd_addr;
        t_slot pv_rd_addr;
        logic  next_we;
        t_slot next_wr_addr;
        t_ptr  next_wr_data;
        logic  prev_we;
        logic  owner_we;
        t_slot pv_wr_addr;
        t_ptr  prev_wr_data;
        t_qid  owner_wr_data;
    } t_lm_req;

    // Registered read data of the link memories.
    typedef struct packed {
        t_ptr next_q;
        t_ptr prev_q;
        t_qid owner_q;
    } t_lm_rsp;

    function automatic logic is_nil(input t_ptr p);
        return p[PTR_W-1];
    endfunction

    function automatic t_ptr slot_ptr(input t_slot s);
        return {1'b0, s};
    endfunction

endpackage

// ===== sv/multi_queue_linked_list_manager_unit.sv =====
// Top level of the linked list queue manager: sequencer and result register.
// Depends on mqll_pkg, mqll_queue_table and mqll_link_mem.
//
// The block keeps sixteen FIFO queues over a pool of 64 slots, each queue a
// doubly linked list. A command arrives on the slave stream: tuser carries
// the opcode (insert, dequeue, remove or no operation), tdata carries the
// queue number and the slot. Every command gives exactly one result on the
// master stream: tdata carries the slot (popped slot of a dequeue, zero for
// an empty dequeue, otherwise the command's slot) and tuser the status.
// One command is worked on at a time. The transfer cycle captures the head,
// tail and queued flag and issues the link memory read; the execute state
// then performs the pointer updates and loads the result register. An insert
// into a non-empty queue passes through the link state as well, since the
// next-pointer memory has a single write port and needs both the new slot and
// the old tail written. The result register is loaded in the command's last
// state. When the receiver stalls, the command in work waits with its updates
// held until the result register can take its result. Reset empties every
// queue; the link memories are not cleared, since a slot's links are written
// before they are read.
module multi_queue_linked_list_manager_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [3:0] queue_id, [9:4] slot, [15:10] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [5:0] slot_out, [7:6] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import mqll_pkg::*;

    t_state  r_state, n_state;
    t_op     r_op;
    t_qid    r_qid;
    t_slot   r_slot;
    t_ptr    r_head;
    t_ptr    r_tail;
    logic    r_queued;
    logic    r_out_valid;
    t_slot   r_out_slot;
    t_status r_out_status;

    t_qid    in_qid;
    t_slot   in_slot;
    t_op     in_op;
    logic    in_xfer;
    logic    out_free;
    logic    finish;
    t_slot   res_slot;
    t_status res_status;

    t_ptr    tb_head;
    t_ptr    tb_tail;
    logic    tb_queued;
    t_qt_wr  qt_wr;
    t_lm_req lm_req;
    t_lm_rsp lm_rsp;

    assign in_qid  = i_s_axis_tdata[QUEUE_W-1:0];
    assign in_slot = i_s_axis_tdata[QUEUE_W+SLOT_W-1:QUEUE_W];
    assign in_op   = t_op'(i_s_axis_tuser);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    mqll_queue_table u_qtab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_qid  (in_qid),
        .i_rd_slot (in_slot),
        .o_head    (tb_head),
        .o_tail    (tb_tail),
        .o_queued  (tb_queued),
        .i_wr      (qt_wr)
    );

    mqll_link_mem u_lmem (
        .i_clk (i_clk),
        .i_req (lm_req),
        .o_rsp (lm_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command registers, loaded in the transfer cycle together with the
    // table lookups that the execute cycle works from.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op     <= in_op;
            r_qid    <= in_qid;
            r_slot   <= in_slot;
            r_head   <= tb_head;
            r_tail   <= tb_tail;
            r_queued <= tb_queued;
        end
    end

    always_comb begin
        n_state    = r_state;
        finish     = 1'b0;
        res_slot   = r_slot;
        res_status = ST_OK;

        qt_wr           = '0;
        qt_wr.qid       = r_qid;
        qt_wr.head_data = NIL_PTR;
        qt_wr.tail_data = NIL_PTR;
        qt_wr.flag_slot = r_slot;

        lm_req               = '0;
        lm_req.next_rd_addr  = (in_op == OP_DEQUEUE) ? tb_head[SLOT_W-1:0] : in_slot;
        lm_req.pv_rd_addr    = in_slot;
        lm_req.next_wr_addr  = r_slot;
        lm_req.next_wr_data  = NIL_PTR;
        lm_req.pv_wr_addr    = r_slot;
        lm_req.prev_wr_data  = NIL_PTR;
        lm_req.owner_wr_data = r_qid;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    lm_req.rd_en = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    finish = 1'b1;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (r_queued) begin
                                res_status = ST_QUEUED;
                            end else begin
                                // New slot becomes the tail; its own next is null.
                                lm_req.prev_we      = 1'b1;
                                lm_req.owner_we     = 1'b1;
                                lm_req.prev_wr_data = r_tail;
                                lm_req.next_we      = 1'b1;
                                qt_wr.flag_we       = 1'b1;
                                qt_wr.flag_val      = 1'b1;
                                qt_wr.tail_we       = 1'b1;
                                qt_wr.tail_data     = slot_ptr(r_slot);
                                if (is_nil(r_head) || is_nil(r_tail)) begin
                                    qt_wr.head_we   = 1'b1;
                                    qt_wr.head_data = slot_ptr(r_slot);
                                end else begin
                                    // Old tail still needs its next pointer.
                                    finish  = 1'b0;
                                    n_state = S_LINK;
                                end
                            end
                        end
                        OP_DEQUEUE: begin
                            if (is_nil(r_head)) begin
                                res_status = ST_EMPTY;
                                res_slot   = '0;
                            end else begin
                                res_slot        = r_head[SLOT_W-1:0];
                                qt_wr.head_we   = 1'b1;
                                qt_wr.head_data = lm_rsp.next_q;
                                qt_wr.flag_we   = 1'b1;
                                qt_wr.flag_slot = r_head[SLOT_W-1:0];
                                if (!is_nil(lm_rsp.next_q)) begin
                                    lm_req.prev_we    = 1'b1;
                                    lm_req.pv_wr_addr = lm_rsp.next_q[SLOT_W-1:0];
                                end else begin
                                    qt_wr.tail_we = 1'b1;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (!r_queued) begin
                                res_status = ST_NOT_QUEUED;
                            end else begin
                                qt_wr.qid     = lm_rsp.owner_q;
                                qt_wr.flag_we = 1'b1;
                                if (!is_nil(lm_rsp.prev_q)) begin
                                    lm_req.next_we      = 1'b1;
                                    lm_req.next_wr_addr = lm_rsp.prev_q[SLOT_W-1:0];
                                    lm_req.next_wr_data = lm_rsp.next_q;
                                end else begin
                                    qt_wr.head_we   = 1'b1;
                                    qt_wr.head_data = lm_rsp.next_q;
                                end
                                if (!is_nil(lm_rsp.next_q)) begin
                                    lm_req.prev_we      = 1'b1;
                                    lm_req.pv_wr_addr   = lm_rsp.next_q[SLOT_W-1:0];
                                    lm_req.prev_wr_data = lm_rsp.prev_q;
                                end else begin
                                    qt_wr.tail_we   = 1'b1;
                                    qt_wr.tail_data = lm_rsp.prev_q;
                                end
                            end
                        end
                        OP_NOP: begin
                            res_status = ST_OK;
                        end
                    endcase
                    if (finish) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LINK: begin
                if (out_free) begin
                    lm_req.next_we      = 1'b1;
                    lm_req.next_wr_addr = r_tail[SLOT_W-1:0];
                    lm_req.next_wr_data = slot_ptr(r_slot);
                    finish              = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_slot   <= res_slot;
            r_out_status <= res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - SLOT_W)'(0), r_out_slot};
    assign o_m_axis_tuser  = r_out_status;

endmodule

// ===== sv/mqll_link_mem.sv =====
// Per-slot link storage: a next-pointer memory and a prev/owner memory.
// Depends on mqll_pkg; both memories have a registered read.
module mqll_link_mem (
    input  logic             i_clk,
    input  mqll_pkg::t_lm_req i_req,
    output mqll_pkg::t_lm_rsp o_rsp
);
    import mqll_pkg::*;

    localparam int PV_W = QUEUE_W + PTR_W;

    t_ptr             r_next_mem [SLOTS];
    logic [PV_W-1:0]  r_pv_mem   [SLOTS];
    t_ptr             r_next_rd;
    logic [PV_W-1:0]  r_pv_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.next_we) begin
            r_next_mem[i_req.next_wr_addr] <= i_req.next_wr_data;
        end
        if (i_req.rd_en) begin
            r_next_rd <= r_next_mem[i_req.next_rd_addr];
        end
    end

    // The prev and owner fields share a word and have their own write lanes.
    always_ff @(posedge i_clk) begin
        if (i_req.prev_we) begin
            r_pv_mem[i_req.pv_wr_addr][PTR_W-1:0] <= i_req.prev_wr_data;
        end
        if (i_req.owner_we) begin
            r_pv_mem[i_req.pv_wr_addr][PV_W-1:PTR_W] <= i_req.owner_wr_data;
        end
        if (i_req.rd_en) begin
            r_pv_rd <= r_pv_mem[i_req.pv_rd_addr];
        end
    end

    assign o_rsp.next_q  = r_next_rd;
    assign o_rsp.prev_q  = r_pv_rd[PTR_W-1:0];
    assign o_rsp.owner_q = r_pv_rd[PV_W-1:PTR_W];

endmodule

// ===== sv/mqll_queue_table.sv =====
// Head and tail pointers of every queue and the queued flag of every slot.
// Depends on mqll_pkg; all entries are flip-flops cleared by reset.
module mqll_queue_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mqll_pkg::t_qid   i_rd_qid,
    input  mqll_pkg::t_slot  i_rd_slot,
    output mqll_pkg::t_ptr   o_head,
    output mqll_pkg::t_ptr   o_tail,
    output logic             o_queued,
    input  mqll_pkg::t_qt_wr i_wr
);
    import mqll_pkg::*;

    t_ptr             r_head [QUEUES];
    t_ptr             r_tail [QUEUES];
    logic [SLOTS-1:0] r_queued;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i] <= NIL_PTR;
                r_tail[i] <= NIL_PTR;
            end
            r_queued <= '0;
        end else begin
            if (i_wr.head_we) begin
                r_head[i_wr.qid] <= i_wr.head_data;
            end
            if (i_wr.tail_we) begin
                r_tail[i_wr.qid] <= i_wr.tail_data;
            end
            if (i_wr.flag_we) begin
                r_queued[i_wr.flag_slot] <= i_wr.flag_val;
            end
        end
    end

    assign o_head   = r_head[i_rd_qid];
    assign o_tail   = r_tail[i_rd_qid];
    assign o_queued = r_queued[i_rd_slot];

endmodule

// ===== sv/mqll_checker.sv =====
// Port-level checker of the linked list queue manager, bound to the top level.
// Depends on mqll_pkg and the assertion macro header.
`include "multi_queue_linked_list_manager_unit_assert.svh"

module mqll_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [15:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import mqll_pkg::*;

    // A stalled result holds.
    `MQLL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    // Only one command is in work: no transfer right after a transfer.
    `MQLL_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "command accepted while another is in work")

    // A result never appears in the cycle right after its command's transfer.
    `MQLL_ASSERT_NXT(a_min_latency, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !$rose(o_m_axis_tvalid), "result came too early")

    // An empty dequeue reports slot zero.
    `MQLL_ASSERT_IMP(a_empty_slot, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY), o_m_axis_tdata == 8'd0, "empty dequeue returned a slot")

endmodule

bind multi_queue_linked_list_manager_unit mqll_checker u_mqll_checker (.*);

// ===== tb/sv/mqll_reply_monitor.sv =====
// Reply monitor for the linked list queue manager: watches both streams, keeps
// its own copy of every queue, predicts each reply and compares. Uses mqll_pkg.
module mqll_reply_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_tvalid,
    input  logic        i_cmd_tready,
    input  logic [15:0] i_cmd_tdata,    // [3:0] queue_id, [9:4] slot, [15:10] zero
    input  logic [1:0]  i_cmd_tuser,    // [1:0] opcode
    input  logic        i_rsp_tvalid,
    input  logic        i_rsp_tready,
    input  logic [7:0]  i_rsp_tdata,    // [5:0] slot_out, [7:6] zero
    input  logic [1:0]  i_rsp_tuser,    // [1:0] status
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import mqll_pkg::*;

    typedef struct packed {
        t_slot   slot;
        t_status status;
    } t_mq_reply;

    // Shadow copy of the queue state.
    t_ptr  shadow_head [QUEUES];
    t_ptr  shadow_tail [QUEUES];
    t_ptr  shadow_next [SLOTS];
    t_ptr  shadow_prev [SLOTS];
    logic  shadow_busy [SLOTS];
    t_qid  shadow_owner[SLOTS];

    t_mq_reply predicted_replies[$];
    int        fail_count = 0;

    function automatic logic ptr_null(input t_ptr p);
        return p[PTR_W-1];
    endfunction

    function automatic void clear_queues();
        for (int i = 0; i < QUEUES; i++) begin
            shadow_head[i] = NIL_PTR;
            shadow_tail[i] = NIL_PTR;
        end
        for (int i = 0; i < SLOTS; i++) begin
            shadow_next[i]  = '0;
            shadow_prev[i]  = '0;
            shadow_busy[i]  = 1'b0;
            shadow_owner[i] = '0;
        end
    endfunction

    function automatic void unlink_slot(input t_slot s);
        shadow_busy[s] = 1'b0;
        shadow_next[s] = NIL_PTR;
        shadow_prev[s] = NIL_PTR;
    endfunction

    // Applies one command to the shadow queues and returns the reply it gives.
    function automatic t_mq_reply apply_command(input t_op op, input t_qid q, input t_slot s);
        t_mq_reply r;
        t_ptr      t;
        t_ptr      h;
        t_ptr      p;
        t_ptr      n;
        t_qid      oq;
        r.slot   = s;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (shadow_busy[s]) begin
                    r.status = ST_QUEUED;
                end else begin
                    t = shadow_tail[q];
                    shadow_prev[s]  = t;
                    shadow_next[s]  = NIL_PTR;
                    shadow_owner[s] = q;
                    shadow_busy[s]  = 1'b1;
                    if (ptr_null(shadow_head[q]) || ptr_null(t)) begin
                        shadow_head[q] = {1'b0, s};
                    end else begin
                        shadow_next[t[SLOT_W-1:0]] = {1'b0, s};
                    end
                    shadow_tail[q] = {1'b0, s};
                end
            end
            OP_DEQUEUE: begin
                h = shadow_head[q];
                if (ptr_null(h)) begin
                    r.status = ST_EMPTY;
                    r.slot   = '0;
                end else begin
                    n = shadow_next[h[SLOT_W-1:0]];
                    shadow_head[q] = n;
                    if (!ptr_null(n)) begin
                        shadow_prev[n[SLOT_W-1:0]] = NIL_PTR;
                    end else begin
                        shadow_tail[q] = NIL_PTR;
                    end
                    unlink_slot(h[SLOT_W-1:0]);
                    r.slot = h[SLOT_W-1:0];
                end
            end
            OP_REMOVE: begin
                if (!shadow_busy[s]) begin
                    r.status = ST_NOT_QUEUED;
                end else begin
                    oq = shadow_owner[s];
                    p  = shadow_prev[s];
                    n  = shadow_next[s];
                    if (!ptr_null(p)) begin
                        shadow_next[p[SLOT_W-1:0]] = n;
                    end else begin
                        shadow_head[oq] = n;
                    end
                    if (!ptr_null(n)) begin
                        shadow_prev[n[SLOT_W-1:0]] = p;
                    end else begin
                        shadow_tail[oq] = p;
                    end
                    unlink_slot(s);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_mq_reply got;
        t_mq_reply want;
        if (!i_rst_n) begin
            clear_queues();
            predicted_replies.delete();
        end else begin
            // Replies are taken before commands, since no reply can belong to
            // a command accepted at the same edge.
            if (i_rsp_tvalid && i_rsp_tready) begin
                got.slot   = i_rsp_tdata[SLOT_W-1:0];
                got.status = t_status'(i_rsp_tuser);
                if (predicted_replies.size() == 0) begin
                    $error("reply with none predicted: slot_out %0d, status %0d",
                           got.slot, got.status);
                    fail_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (got.slot !== want.slot) begin
                        $error("slot_out: expected %0d, actual %0d", want.slot, got.slot);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fail_count++;
                    end
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                predicted_replies.push_back(apply_command(t_op'(i_cmd_tuser),
                                                          i_cmd_tdata[3:0],
                                                          i_cmd_tdata[9:4]));
            end
        end
        o_outstanding = predicted_replies.size();
        o_fail_count  = fail_count;
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the linked list queue manager: clock, reset, command and
// reply stream drivers, watchdog and verdict. Uses mqll_pkg, mqll_reply_monitor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mqll_pkg::*;

    // Cycles without any transfer before the run is declared hung. The limit
    // lies well above the long receiver hold below, leaving a wide margin.
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 1450;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // [3:0] queue_id, [9:4] slot, [15:10] zero
    logic [1:0]  s_axis_tuser;     // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // [5:0] slot_out, [7:6] zero
    logic [1:0]  m_axis_tuser;     // [1:0] status

    int fail_count;
    int outstanding;
    int idle_cycles = 0;

    // Pacing controls of the stimulus; long_hold_req is shared with the receiver process.
    logic send_back_to_back = 1'b0;
    logic long_hold_req     = 1'b0;

    always #10 i_clk = ~i_clk;

    multi_queue_linked_list_manager_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    mqll_reply_monitor monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_tvalid  (s_axis_tvalid),
        .i_cmd_tready  (s_axis_tready),
        .i_cmd_tdata   (s_axis_tdata),
        .i_cmd_tuser   (s_axis_tuser),
        .i_rsp_tvalid  (m_axis_tvalid),
        .i_rsp_tready  (m_axis_tready),
        .i_rsp_tdata   (m_axis_tdata),
        .i_rsp_tuser   (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Offers one command, after a random number of idle cycles unless the
    // current stretch is back to back. The task is entered and left at a
    // falling edge; tvalid stays high between back-to-back transfers.
    task automatic send_cmd(input t_op op, input t_qid q, input t_slot s);
        int gap;
        gap = send_back_to_back ? 0 : $urandom_range(0, 14);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, s, q};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
    endtask

    // Reply side. Each reply waits a random stall first; on request from the
    // stimulus the receiver instead holds off for a long stretch, so that the
    // result register fills, the command in work stalls, and tready drops on
    // the command side while the sender keeps offering.
    initial begin : receiver
        int stall;
        logic fast;
        m_axis_tready = 1'b0;
        fast = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end else begin
                if ($urandom_range(0, 39) == 0) begin
                    fast = ~fast;
                end
                stall = fast ? 0 : $urandom_range(0, 14);
            end
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge i_clk);
        end
    end

    // Watchdog: counts cycles in which neither stream makes a transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            idle_cycles <= 0;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("multi_queue_linked_list_manager_unit: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int   ins_pct;
        int   deq_pct;
        int   roll;
        t_op  op;
        t_qid qid;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NOP;
        ins_pct       = 50;
        deq_pct       = 20;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Queue 15 is built as 63, 5, 42 and queue 0 as 0, 21,
        // then slots are taken out from the middle, the tail and the head.
        send_cmd(OP_INSERT,  4'd0,  6'd0);
        send_cmd(OP_INSERT,  4'd15, 6'd63);
        send_cmd(OP_INSERT,  4'd0,  6'd63);   // slot already queued elsewhere
        send_cmd(OP_INSERT,  4'd15, 6'd5);    // insert behind an existing tail
        send_cmd(OP_INSERT,  4'd15, 6'd42);
        send_cmd(OP_INSERT,  4'd0,  6'd21);
        send_cmd(OP_DEQUEUE, 4'd3,  6'd63);   // empty queue, slot field ignored
        send_cmd(OP_REMOVE,  4'd9,  6'd40);   // slot that was never queued
        send_cmd(OP_REMOVE,  4'd7,  6'd5);    // middle of queue 15
        send_cmd(OP_REMOVE,  4'd0,  6'd42);   // tail of queue 15
        send_cmd(OP_REMOVE,  4'd15, 6'd0);    // head of queue 0
        send_cmd(OP_DEQUEUE, 4'd15, 6'd0);
        send_cmd(OP_DEQUEUE, 4'd15, 6'd0);    // now empty again
        send_cmd(OP_DEQUEUE, 4'd0,  6'd63);
        send_cmd(OP_NOP,     4'd15, 6'd63);
        send_cmd(OP_NOP,     4'd0,  6'd0);
        send_cmd(OP_NOP,     4'd10, 6'd42);
        send_cmd(OP_INSERT,  4'd10, 6'd42);
        send_cmd(OP_DEQUEUE, 4'd10, 6'd21);
        send_cmd(OP_REMOVE,  4'd0,  6'd63);   // slot was dequeued, so not queued

        // Random part, in segments of 50 commands. Each segment draws its own
        // mix, so the pool alternates between filling up and draining, and
        // most commands go to a few queues so that lists grow long.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                ins_pct = $urandom_range(25, 60);
                deq_pct = (95 - ins_pct) / 2;
                send_back_to_back = ($urandom_range(0, 3) == 0);
                // Two segments run back to back against a long receiver hold.
                if (i == 400 || i == 1000) begin
                    send_back_to_back = 1'b1;
                    long_hold_req     = 1'b1;
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) begin
                op = OP_INSERT;
            end else if (roll < ins_pct + deq_pct) begin
                op = OP_DEQUEUE;
            end else if (roll < 95) begin
                op = OP_REMOVE;
            end else begin
                op = OP_NOP;
            end
            qid = ($urandom_range(0, 9) < 7) ? t_qid'($urandom_range(0, 3))
                                               : t_qid'($urandom_range(0, 15));
            send_cmd(op, qid, t_slot'($urandom_range(0, 63)));
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every predicted reply, then wait on so that a stray
        // extra reply would still be caught.
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("multi_queue_linked_list_manager_unit: match");
        end else begin
            $display("multi_queue_linked_list_manager_unit: mismatch");
        end
        $finish;
    end

endmodule
